// ----- rtl/bme_pkg.sv -----
// ----------------------------------------------------------------------------
// bme_pkg
// Shared types, register indexes and helper functions for the braid
// message encoder.
// ----------------------------------------------------------------------------
package bme_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_STRANDS  = 3'd0;
   localparam logic [2:0] CSR_GEN_SEL0 = 3'd1;
   localparam logic [2:0] CSR_GEN_SEL1 = 3'd2;
   localparam logic [2:0] CSR_GEN_SEL2 = 3'd3;
   localparam logic [2:0] CSR_GEN_SEL3 = 3'd4;

   localparam logic [3:0] MIN_STRANDS = 4'd3;

   // input transaction
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       msg_last;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [4:0] artin_gen;
      logic              run_last;
   } rsp_type;

   // live configuration, strand count already clamped
   typedef struct packed {
      logic [3:0]      n;
      logic [3:0][3:0] gen_sel;
   } cfg_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic       first;
      logic       last;
      logic [3:0] g_hi;
      logic [2:0] p_hi;
      logic [3:0] g_lo;
      logic [2:0] p_lo;
   } desc_type;

   function automatic logic [3:0] clamp_strands(input logic [3:0] s, input logic [3:0] maxs);
      logic [3:0] r;
      r = s;
      if (r < MIN_STRANDS) r = MIN_STRANDS;
      if (r > maxs) r = maxs;
      return r;
   endfunction

   function automatic logic [3:0] clamp_gen(input logic [3:0] g, input logic [3:0] n);
      logic [3:0] r;
      r = g;
      if (r < 4'd1) r = 4'd1;
      if (r > n - 4'd1) r = n - 4'd1;
      return r;
   endfunction

endpackage

// ----- rtl/bme_fifo.sv -----
// ----------------------------------------------------------------------------
// bme_fifo
// Small synchronous queue with registered storage, used between the front
// and back parts and in front of the result port.
// ----------------------------------------------------------------------------
module bme_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem[rd_ptr_ff];

   // pointer and count update, wrap at DEPTH
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= wdata;
   end

endmodule

// ----- rtl/bme_front.sv -----
// ----------------------------------------------------------------------------
// bme_front
// Accepts message bytes, maps both nibbles to generator and power, and
// tags the first and last byte of each message.
// ----------------------------------------------------------------------------
module bme_front (
   input  logic              clock,
   input  logic              reset,
   input  bme_pkg::cfg_type  cfg,
   input  logic              req_push,
   input  bme_pkg::req_type  req_data,
   output logic              req_full,
   input  logic              desc_full,
   output logic              desc_push,
   output bme_pkg::desc_type desc_data
);
   import bme_pkg::*;

   logic       first_ff, first_in;
   logic [3:0] hi, lo;
   logic       accept;

   assign hi       = req_data.msg_byte[7:4];
   assign lo       = req_data.msg_byte[3:0];
   assign req_full = desc_full;
   assign accept   = req_push & ~desc_full;
   assign desc_push = accept;

   // classify the byte
   always_comb begin
      desc_data.first = first_ff;
      desc_data.last  = req_data.msg_last;
      desc_data.g_hi  = clamp_gen(cfg.gen_sel[hi[1:0]], cfg.n);
      desc_data.p_hi  = {1'b0, hi[3:2]} + 3'd1;
      desc_data.g_lo  = clamp_gen(cfg.gen_sel[lo[1:0]], cfg.n);
      desc_data.p_lo  = {1'b0, lo[3:2]} + 3'd1;
   end

   // next byte opens a new message once the last byte went through
   always_comb begin
      first_in = first_ff;
      if (accept) first_in = req_data.msg_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

endmodule

// ----- rtl/bme_back.sv -----
// ----------------------------------------------------------------------------
// bme_back
// Sequencer that expands one classified byte into generators: prefix,
// power runs, connectors and tail, one generator per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module bme_back (
   input  logic              clock,
   input  logic              reset,
   input  bme_pkg::cfg_type  cfg,
   input  logic              desc_empty,
   input  bme_pkg::desc_type desc_data,
   output logic              desc_pop,
   input  logic              out_full,
   output logic              out_push,
   output bme_pkg::rsp_type  out_data
);
   import bme_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_PREFIX = 5'b00010,
      S_RUN    = 5'b00100,
      S_CONN   = 5'b01000,
      S_TAIL   = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      TGT_HI,
      TGT_LO,
      TGT_END
   } tgt_type;

   state_type state_ff, state_in;
   tgt_type   tgt_ff, tgt_in;
   desc_type  d_ff, d_in;
   logic [3:0] held_gen_ff, held_gen_in;
   logic [2:0] held_pow_ff, held_pow_in;
   logic       drop_ff, drop_in;
   logic       dsc_ff, dsc_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [3:0] cur_ff, cur_in;

   logic [3:0] ga, tg, total, n_top;
   logic       go;

   assign go    = ~out_full;
   assign ga    = clamp_gen(held_gen_ff, cfg.n);
   assign tg    = (tgt_ff == TGT_HI) ? d_ff.g_hi : d_ff.g_lo;
   assign total = {held_pow_ff, 1'b0} - {3'd0, drop_ff};
   assign n_top = cfg.n - 4'd1;

   always_comb begin
      state_in    = state_ff;
      tgt_in      = tgt_ff;
      d_in        = d_ff;
      held_gen_in = held_gen_ff;
      held_pow_in = held_pow_ff;
      drop_in     = drop_ff;
      dsc_in      = dsc_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      desc_pop    = 1'b0;
      out_push    = 1'b0;
      out_data.artin_gen = '0;
      out_data.run_last  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (!desc_empty) begin
               desc_pop = 1'b1;
               d_in     = desc_data;
               if (desc_data.first) begin
                  cur_in   = n_top;
                  state_in = S_PREFIX;
               end else begin
                  tgt_in   = TGT_HI;
                  cnt_in   = '0;
                  state_in = S_RUN;
               end
            end
         end

         // descending prefix down to the high nibble's generator
         S_PREFIX: begin
            if (go) begin
               if (cur_ff > d_ff.g_hi) begin
                  out_push           = 1'b1;
                  out_data.artin_gen = $signed({1'b0, cur_ff});
                  cur_in             = cur_ff - 4'd1;
               end else begin
                  held_gen_in = d_ff.g_hi;
                  held_pow_in = d_ff.p_hi;
                  drop_in     = 1'b0;
                  tgt_in      = TGT_LO;
                  cnt_in      = '0;
                  state_in    = S_RUN;
               end
            end
         end

         // power run of the held generator, never empty
         S_RUN: begin
            if (go) begin
               out_push           = 1'b1;
               out_data.artin_gen = $signed({1'b0, ga});
               if (cnt_ff == total - 4'd1) begin
                  if (tgt_ff == TGT_END) begin
                     if (ga == n_top) begin
                        out_data.run_last = 1'b1;
                        drop_in           = 1'b0;
                        state_in          = S_IDLE;
                     end else begin
                        cur_in   = ga + 4'd1;
                        state_in = S_TAIL;
                     end
                  end else begin
                     dsc_in   = (ga >= tg);
                     cur_in   = (ga >= tg) ? ga : ga + 4'd1;
                     state_in = S_CONN;
                  end
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end

         // connector toward the target generator
         S_CONN: begin
            if (go) begin
               if (dsc_ff ? (cur_ff > tg) : (cur_ff < tg)) begin
                  out_push           = 1'b1;
                  out_data.artin_gen = dsc_ff ? $signed({1'b0, cur_ff})
                                              : -$signed({1'b0, cur_ff});
                  cur_in             = dsc_ff ? cur_ff - 4'd1 : cur_ff + 4'd1;
               end else begin
                  drop_in     = ~dsc_ff;
                  held_gen_in = tg;
                  held_pow_in = (tgt_ff == TGT_HI) ? d_ff.p_hi : d_ff.p_lo;
                  cnt_in      = '0;
                  if (tgt_ff == TGT_HI) begin
                     tgt_in   = TGT_LO;
                     state_in = S_RUN;
                  end else if (d_ff.last) begin
                     tgt_in   = TGT_END;
                     state_in = S_RUN;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end

         // negated ascending tail up to the top strand
         S_TAIL: begin
            if (go) begin
               out_push           = 1'b1;
               out_data.artin_gen = -$signed({1'b0, cur_ff});
               if (cur_ff == n_top) begin
                  out_data.run_last = 1'b1;
                  drop_in           = 1'b0;
                  state_in          = S_IDLE;
               end else begin
                  cur_in = cur_ff + 4'd1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tgt_ff      <= TGT_HI;
         held_gen_ff <= '0;
         held_pow_ff <= '0;
         drop_ff     <= 1'b0;
         dsc_ff      <= 1'b0;
         cnt_ff      <= '0;
         cur_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         tgt_ff      <= tgt_in;
         held_gen_ff <= held_gen_in;
         held_pow_ff <= held_pow_in;
         drop_ff     <= drop_in;
         dsc_ff      <= dsc_in;
         cnt_ff      <= cnt_in;
         cur_ff      <= cur_in;
      end
   end

   // byte being expanded, payload only
   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

endmodule

// ----- rtl/braid_message_encoder.sv -----
// ----------------------------------------------------------------------------
// braid_message_encoder
// Encodes message bytes into a signed Artin generator word; front part
// classifies bytes, back part emits generators through a result queue.
// ----------------------------------------------------------------------------
// Path: the idle sequencer loads a byte from the descriptor queue, and its
//   first generator then passes through the result queue; a first byte
//   with an empty prefix first passes the closing prefix check.
// Throughput: one generator per cycle while the result queue has room; a new
//   byte is loaded only from idle; loads and prefix/connector closing checks emit nothing.
// Reset: synchronous; clears both queues, the message state and the
//   configuration registers to strands 8 and generators 1, 2, 3, 4.
module braid_message_encoder #(
   parameter int MAX_STRANDS = 8
) (
   input  logic             clock,
   input  logic             reset,
   // byte input
   input  logic             req_push,
   input  bme_pkg::req_type req_data,
   output logic             req_full,
   // generator output
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output bme_pkg::rsp_type rsp_data,
   // configuration writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [3:0]       csr_wdata
);
   import bme_pkg::*;

   localparam int DESC_W = $bits(desc_type);
   localparam int RSP_W  = $bits(rsp_type);

   logic [3:0]      strands_ff, strands_in;
   logic [3:0][3:0] gen_sel_ff, gen_sel_in;
   cfg_type         cfg;

   logic     desc_push, desc_full, desc_empty, desc_pop;
   desc_type desc_wdata, desc_rdata;
   logic     out_push, out_full;
   rsp_type  out_wdata;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      strands_in = strands_ff;
      gen_sel_in = gen_sel_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_STRANDS:  strands_in    = csr_wdata;
            CSR_GEN_SEL0: gen_sel_in[0] = csr_wdata;
            CSR_GEN_SEL1: gen_sel_in[1] = csr_wdata;
            CSR_GEN_SEL2: gen_sel_in[2] = csr_wdata;
            CSR_GEN_SEL3: gen_sel_in[3] = csr_wdata;
            default: begin
               strands_in = strands_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strands_ff <= 4'd8;
         gen_sel_ff <= {4'd4, 4'd3, 4'd2, 4'd1};
      end else begin
         strands_ff <= strands_in;
         gen_sel_ff <= gen_sel_in;
      end
   end

   assign cfg.n       = clamp_strands(strands_ff, 4'(MAX_STRANDS));
   assign cfg.gen_sel = gen_sel_ff;

   bme_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .desc_full (desc_full),
      .desc_push (desc_push),
      .desc_data (desc_wdata)
   );

   bme_fifo #(.WIDTH(DESC_W), .DEPTH(2)) u_desc_q (
      .clock (clock),
      .reset (reset),
      .push  (desc_push),
      .wdata (desc_wdata),
      .full  (desc_full),
      .pop   (desc_pop),
      .rdata (desc_rdata),
      .empty (desc_empty)
   );

   bme_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .desc_empty (desc_empty),
      .desc_data  (desc_rdata),
      .desc_pop   (desc_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_wdata)
   );

   bme_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_data),
      .empty (rsp_empty)
   );

endmodule

// ----- rtl/bme_check.sv -----
// ----------------------------------------------------------------------------
// bme_check
// Port-level checks for the braid message encoder, bound to the top level.
// ----------------------------------------------------------------------------
module bme_check (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input bme_pkg::rsp_type rsp_data
);
   import bme_pkg::*;

   // result queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a generator is never zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.artin_gen != 5'sd0)
      else $error("zero generator emitted");

   // generator magnitude stays within twelve strands
   a_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.artin_gen <= 5'sd11 && rsp_data.artin_gen >= -5'sd11))
      else $error("generator out of range");

   // a waiting transaction holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting result changed");

endmodule

bind braid_message_encoder bme_check u_bme_check (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
